// ----- sv/wbe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes of the windowed binary entropy estimator.
// Used by every module of the block; depends on nothing.
package wbe_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned MAX_WINDOW  = 65536;
  localparam int unsigned MANT_FRAC   = 30;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned WIN_W   = 17;
  localparam int unsigned TOT_W   = 27;
  localparam int unsigned IDX_W   = 26;
  localparam int unsigned ENT_W   = 17;
  localparam int unsigned VAR_W   = 15;
  localparam int unsigned SUM_W   = 42;
  localparam int unsigned SQ_W    = 58;
  localparam int unsigned EXP_W   = 5;
  localparam int unsigned LOG_W   = EXP_W + FRAC_BITS;
  localparam int unsigned MANT_W  = 32;
  localparam int unsigned WIDE_W  = 84;
  localparam int unsigned MB_W    = 42;
  localparam int unsigned DVS_W   = 52;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BITS  = 1'd1;

  localparam logic KIND_ESTIMATE = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(65536);
  localparam logic [TOT_W-1:0] TOT_RESET = TOT_W'(65536);
  localparam logic [ENT_W-1:0] ENT_MAX   = ENT_W'(1 << FRAC_BITS);

  // One unit of work handed from the front end to the back end.
  typedef struct packed {
    logic             est;    // a window closed: compute its entropy
    logic             summ;   // emit the summary afterwards
    logic [WIN_W-1:0] ones;
    logic [WIN_W-1:0] nbits;
  } wbe_job_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] idx;
    logic [ENT_W-1:0] entropy;
    logic [ENT_W-1:0] mean;
    logic [VAR_W-1:0] variance;
    logic             last;
  } wbe_result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOG_INIT, S_LOG_STEP, S_MUL_INIT, S_MUL_STEP, S_DIV_INIT,
    S_DIV_STEP, S_ACC, S_EST_WAIT, S_SUM, S_SUM_LOAD, S_SUM_WAIT
  } wbe_state_t;

  typedef enum logic [3:0] {
    PH_LW, PH_LK, PH_LWK, PH_MA, PH_MB1, PH_MB2, PH_DH, PH_DMEAN,
    PH_MLHS, PH_MRHS, PH_MNN, PH_DVAR
  } wbe_phase_t;

endpackage

// ----- sv/windowed_binary_entropy_estimator_core.sv -----
`timescale 1ns / 1ps
// Windowed binary entropy estimator, top level.
// Throughput: one bit per cycle while the job queue has room; the back end handles one
// job at a time (per non-trivial window three 16-step log2 runs, serial multiplies
// and an 84-step divide), so short windows stall input once QDEPTH jobs are queued.
// Reset is synchronous and restarts the analysis.
module windowed_binary_entropy_estimator_core import wbe_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port; no read-back.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] bit_req, [7:1] unused
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [25:0] estimate_index, [42:26] entropy, [59:43] mean, [74:60] variance,
  // [79:75] zero
  output logic [79:0]           m_axis_tdata,
  output logic [0:0]            m_axis_tuser,   // [0] kind
  output logic                  m_axis_tlast
);

  // The two configuration registers. Writes land immediately and never
  // disturb the running analysis state.
  logic [WIN_W-1:0] window_bits;
  logic [TOT_W-1:0] total_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= WIN_RESET;
      total_bits  <= TOT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WINDOW_BITS) begin
        window_bits <= cfg_data[WIN_W-1:0];
      end else if (cfg_index == CFG_TOTAL_BITS) begin
        total_bits <= cfg_data[TOT_W-1:0];
      end
    end
  end

  // The front end counts bits and turns each window close (and the final
  // summary) into a queued job, so the link waits on the math only while
  // the job queue is full.
  logic        push;
  wbe_job_t    job;
  wbe_job_t    q_head;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  wbe_result_t res;

  wbe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .bit_req     (s_axis_tdata[0]),
    .window_bits (window_bits),
    .total_bits  (total_bits),
    .q_full      (q_full),
    .push        (push),
    .job         (job)
  );

  wbe_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (job),
    .pop    (q_pop),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  // The back end drains jobs one at a time and holds each result in its
  // output register until the transfer completes.
  wbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {5'd0, res.variance, res.mean, res.entropy, res.idx};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
  // Only the summary carries the last flag.
  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]))
    else $error("tlast and kind disagree");

  // Estimates carry an entropy no larger than one and zero statistics.
  a_estimate_fields: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[0] == KIND_ESTIMATE)) |->
      ((m_axis_tdata[42:26] <= ENT_MAX) && (m_axis_tdata[74:43] == '0)))
    else $error("bad estimate fields");

  // A reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");
`endif

endmodule

// ----- sv/wbe_front.sv -----
`timescale 1ns / 1ps
// Front end: takes one bit per transfer, counts windows and queues jobs.
// Depends on wbe_pkg.
module wbe_front import wbe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             bit_req,
  input  logic [WIN_W-1:0] window_bits,
  input  logic [TOT_W-1:0] total_bits,
  input  logic             q_full,
  output logic             push,
  output wbe_job_t         job
);

  logic [WIN_W-1:0] ones;
  logic [WIN_W-1:0] nbits;
  logic [IDX_W-1:0] est_count;
  logic             finished;

  logic [WIN_W-1:0]       w_eff;
  logic [IDX_W:0]         cnt1;
  logic [IDX_W+WIN_W:0]   p1;
  logic [IDX_W+WIN_W+1:0] p2;
  logic                   target_met;
  logic                   last_close;
  logic [WIN_W-1:0]       nb1;
  logic [WIN_W-1:0]       k1;
  logic                   close;
  logic                   take;

  always_comb begin
    if (window_bits < WIN_W'(2)) begin
      w_eff = WIN_W'(2);
    end else if (window_bits > WIN_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = window_bits;
    end
  end

  // Target reached when (done+1)*w exceeds the total; no divide needed.
  assign cnt1       = (IDX_W+1)'(est_count) + (IDX_W+1)'(1);
  assign p1         = (IDX_W+WIN_W+1)'(cnt1) * (IDX_W+WIN_W+1)'(w_eff);
  assign p2         = (IDX_W+WIN_W+2)'(p1) + (IDX_W+WIN_W+2)'(w_eff);
  assign target_met = p1 > (IDX_W+WIN_W+1)'(total_bits);
  assign last_close = p2 > (IDX_W+WIN_W+2)'(total_bits);

  assign nb1   = nbits + WIN_W'(1);
  assign k1    = ones + WIN_W'(bit_req);
  assign close = nb1 >= w_eff;

  assign in_ready = finished || !q_full;
  assign take     = in_valid && in_ready && !finished;

  always_comb begin
    push      = 1'b0;
    job.est   = 1'b0;
    job.summ  = 1'b0;
    job.ones  = k1;
    job.nbits = nb1;
    if (take) begin
      if (target_met) begin
        push     = 1'b1;
        job.summ = 1'b1;
      end else if (close) begin
        push     = 1'b1;
        job.est  = 1'b1;
        job.summ = last_close;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ones      <= '0;
      nbits     <= '0;
      est_count <= '0;
      finished  <= 1'b0;
    end else if (take) begin
      if (target_met) begin
        finished <= 1'b1;
      end else if (close) begin
        ones      <= '0;
        nbits     <= '0;
        est_count <= est_count + IDX_W'(1);
        finished  <= last_close;
      end else begin
        ones  <= k1;
        nbits <= nb1;
      end
    end
  end

endmodule

// ----- sv/wbe_fifo.sv -----
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
// Depends on wbe_pkg.
module wbe_fifo import wbe_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  wbe_job_t wr_job,
  input  logic     pop,
  output wbe_job_t head,
  output logic     full,
  output logic     empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wbe_job_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/wbe_back.sv -----
`timescale 1ns / 1ps
// Back end: entropy of each window, running sums and the final summary,
// built on an iterative log2, a serial multiplier and a restoring divider.
// Depends on wbe_pkg.
module wbe_back import wbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  wbe_job_t    q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output wbe_result_t out_res
);

  localparam int unsigned LCNT_W = $clog2(FRAC_BITS);
  localparam int unsigned DCNT_W = $clog2(WIDE_W + 1);

  wbe_state_t state, state_next;
  wbe_phase_t phase, phase_next;

  logic             j_summ;
  logic [WIN_W-1:0] j_k;
  logic [WIN_W-1:0] j_w;
  logic [LOG_W-1:0] l_w;
  logic [LOG_W-1:0] l_k;
  logic [LOG_W-1:0] l_wk;

  logic [MANT_W-1:0]    lg_m;
  logic [FRAC_BITS-1:0] lg_frac;
  logic [EXP_W-1:0]     lg_exp;
  logic [LCNT_W-1:0]    lg_cnt;

  logic [WIDE_W-1:0] mu_a;
  logic [MB_W-1:0]   mu_b;
  logic [WIDE_W-1:0] mu_acc;

  logic [WIDE_W-1:0] dv_num;
  logic [DVS_W-1:0]  dv_rem;
  logic [DVS_W-1:0]  dv_d;
  logic [DCNT_W-1:0] dv_cnt;

  logic [SUM_W-1:0]  ent_sum;
  logic [SQ_W-1:0]   sq_sum;
  logic [IDX_W-1:0]  n_est;
  logic [WIDE_W-1:0] acc_a;
  logic [WIDE_W-1:0] acc_b;
  logic [DVS_W-1:0]  nn_r;
  logic [ENT_W-1:0]  h_r;
  logic [ENT_W-1:0]  mean_r;
  logic [VAR_W-1:0]  var_r;

  // Log2 datapath.
  logic [WIN_W-1:0]        lg_x;
  logic [EXP_W-1:0]        x_exp;
  logic [MANT_W-1:0]       m_init;
  logic [2*MANT_W-3:0]     sq_full;
  logic [MANT_W-1:0]       sq;
  logic                    lg_bit;
  logic [MANT_W-1:0]       m_next;
  logic [FRAC_BITS-1:0]    frac_next;
  logic                    lg_last;

  // Multiplier and divider operands and steps.
  logic [WIDE_W-1:0] op_a;
  logic [MB_W-1:0]   op_b;
  logic [WIDE_W-1:0] dv_n0;
  logic [DVS_W-1:0]  dv_d0;
  logic [DVS_W:0]    rem_sh;
  logic              dv_ge;
  logic [DVS_W:0]    rem_n;
  logic              mu_done;
  logic              dv_done;

  logic             trivial;
  logic [WIDE_W-1:0] b_total;
  logic             b_ge_a;
  logic             lhs_lt;
  logic [ENT_W-1:0] h_sat;
  logic [2*ENT_W-1:0] h_sq;

  always_comb begin
    unique case (phase)
      PH_LW:   lg_x = j_w;
      PH_LK:   lg_x = j_k;
      default: lg_x = j_w - j_k;
    endcase
    x_exp = '0;
    for (int i = 0; i < WIN_W; i++) begin
      if (lg_x[i]) begin
        x_exp = EXP_W'(i);
      end
    end
    m_init    = MANT_W'(lg_x) << (EXP_W'(MANT_FRAC) - x_exp);
    sq_full   = lg_m[MANT_W-2:0] * lg_m[MANT_W-2:0];
    sq        = sq_full[2*MANT_W-3:MANT_FRAC];
    lg_bit    = sq[MANT_W-1];
    m_next    = lg_bit ? {1'b0, sq[MANT_W-1:1]} : sq;
    frac_next = {lg_frac[FRAC_BITS-2:0], lg_bit};
    lg_last   = lg_cnt == LCNT_W'(FRAC_BITS - 1);
  end

  always_comb begin
    unique case (phase)
      PH_MA: begin
        op_a = WIDE_W'(l_w);
        op_b = MB_W'(j_w);
      end
      PH_MB1: begin
        op_a = WIDE_W'(l_k);
        op_b = MB_W'(j_k);
      end
      PH_MB2: begin
        op_a = WIDE_W'(l_wk);
        op_b = MB_W'(j_w - j_k);
      end
      PH_MLHS: begin
        op_a = WIDE_W'(sq_sum);
        op_b = MB_W'(n_est);
      end
      PH_MRHS: begin
        op_a = WIDE_W'(ent_sum);
        op_b = ent_sum;
      end
      default: begin
        op_a = WIDE_W'(n_est);
        op_b = MB_W'(n_est);
      end
    endcase
    unique case (phase)
      PH_DH: begin
        dv_n0 = acc_a - acc_b;
        dv_d0 = DVS_W'(j_w);
      end
      PH_DMEAN: begin
        dv_n0 = WIDE_W'(ent_sum);
        dv_d0 = DVS_W'(n_est);
      end
      default: begin
        dv_n0 = acc_a - acc_b;
        dv_d0 = nn_r;
      end
    endcase
    rem_sh  = {dv_rem, dv_num[WIDE_W-1]};
    dv_ge   = rem_sh >= {1'b0, dv_d};
    rem_n   = dv_ge ? rem_sh - {1'b0, dv_d} : rem_sh;
    mu_done = mu_b == '0;
    dv_done = dv_cnt == DCNT_W'(WIDE_W);

    trivial = (q_head.ones == '0) || (q_head.ones >= q_head.nbits);
    b_total = acc_b + mu_acc;
    b_ge_a  = b_total >= acc_a;
    lhs_lt  = acc_a < acc_b;
    h_sat   = (dv_num > WIDE_W'(ENT_MAX)) ? ENT_MAX : dv_num[ENT_W-1:0];
    h_sq    = h_r * h_r;
  end

  // Next state.
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          if (!q_head.est) begin
            state_next = S_SUM;
          end else if (trivial) begin
            state_next = S_ACC;
          end else begin
            state_next = S_LOG_INIT;
            phase_next = PH_LW;
          end
        end
      end
      S_LOG_INIT: state_next = S_LOG_STEP;
      S_LOG_STEP: begin
        if (lg_last) begin
          state_next = S_LOG_INIT;
          priority case (phase)
            PH_LW: phase_next = PH_LK;
            PH_LK: phase_next = PH_LWK;
            default: begin
              phase_next = PH_MA;
              state_next = S_MUL_INIT;
            end
          endcase
        end
      end
      S_MUL_INIT: state_next = S_MUL_STEP;
      S_MUL_STEP: begin
        if (mu_done) begin
          state_next = S_MUL_INIT;
          priority case (phase)
            PH_MA:   phase_next = PH_MB1;
            PH_MB1:  phase_next = PH_MB2;
            PH_MB2: begin
              if (b_ge_a) begin
                state_next = S_ACC;
              end else begin
                state_next = S_DIV_INIT;
                phase_next = PH_DH;
              end
            end
            PH_MLHS: phase_next = PH_MRHS;
            PH_MRHS: phase_next = PH_MNN;
            default: begin
              if (lhs_lt) begin
                state_next = S_SUM_LOAD;
              end else begin
                state_next = S_DIV_INIT;
                phase_next = PH_DVAR;
              end
            end
          endcase
        end
      end
      S_DIV_INIT: state_next = S_DIV_STEP;
      S_DIV_STEP: begin
        if (dv_done) begin
          priority case (phase)
            PH_DH: state_next = S_ACC;
            PH_DMEAN: begin
              state_next = S_MUL_INIT;
              phase_next = PH_MLHS;
            end
            default: state_next = S_SUM_LOAD;
          endcase
        end
      end
      S_ACC: state_next = S_EST_WAIT;
      S_EST_WAIT: begin
        if (out_ready) begin
          state_next = j_summ ? S_SUM : S_IDLE;
        end
      end
      S_SUM: begin
        if (n_est == '0) begin
          state_next = S_SUM_LOAD;
        end else begin
          state_next = S_DIV_INIT;
          phase_next = PH_DMEAN;
        end
      end
      S_SUM_LOAD: state_next = S_SUM_WAIT;
      S_SUM_WAIT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop = (state == S_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_LW;
      out_valid <= 1'b0;
      ent_sum   <= '0;
      sq_sum    <= '0;
      n_est     <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            j_summ <= q_head.summ;
            j_k    <= q_head.ones;
            j_w    <= q_head.nbits;
            h_r    <= '0;
          end
        end
        S_LOG_INIT: begin
          lg_m    <= m_init;
          lg_exp  <= x_exp;
          lg_frac <= '0;
          lg_cnt  <= '0;
        end
        S_LOG_STEP: begin
          lg_m    <= m_next;
          lg_frac <= frac_next;
          lg_cnt  <= lg_cnt + LCNT_W'(1);
          if (lg_last) begin
            priority case (phase)
              PH_LW:   l_w  <= {lg_exp, frac_next};
              PH_LK:   l_k  <= {lg_exp, frac_next};
              default: l_wk <= {lg_exp, frac_next};
            endcase
          end
        end
        S_MUL_INIT: begin
          mu_a   <= op_a;
          mu_b   <= op_b;
          mu_acc <= '0;
        end
        S_MUL_STEP: begin
          if (!mu_done) begin
            if (mu_b[0]) begin
              mu_acc <= mu_acc + mu_a;
            end
            mu_a <= {mu_a[WIDE_W-2:0], 1'b0};
            mu_b <= {1'b0, mu_b[MB_W-1:1]};
          end else begin
            priority case (phase)
              PH_MA:   acc_a <= mu_acc;
              PH_MB1:  acc_b <= mu_acc;
              PH_MB2:  acc_b <= b_total;
              PH_MLHS: acc_a <= mu_acc;
              PH_MRHS: acc_b <= mu_acc;
              default: nn_r  <= mu_acc[DVS_W-1:0];
            endcase
          end
        end
        S_DIV_INIT: begin
          dv_num <= dv_n0;
          dv_d   <= dv_d0;
          dv_rem <= '0;
          dv_cnt <= '0;
        end
        S_DIV_STEP: begin
          if (!dv_done) begin
            dv_num <= {dv_num[WIDE_W-2:0], dv_ge};
            dv_rem <= rem_n[DVS_W-1:0];
            dv_cnt <= dv_cnt + DCNT_W'(1);
          end else begin
            priority case (phase)
              PH_DH:    h_r    <= h_sat;
              PH_DMEAN: mean_r <= dv_num[ENT_W-1:0];
              default:  var_r  <= dv_num[FRAC_BITS+VAR_W-1:FRAC_BITS];
            endcase
          end
        end
        S_ACC: begin
          ent_sum          <= ent_sum + SUM_W'(h_r);
          sq_sum           <= sq_sum + SQ_W'(h_sq);
          n_est            <= n_est + IDX_W'(1);
          out_res.kind     <= KIND_ESTIMATE;
          out_res.idx      <= n_est;
          out_res.entropy  <= h_r;
          out_res.mean     <= '0;
          out_res.variance <= '0;
          out_res.last     <= 1'b0;
          out_valid        <= 1'b1;
        end
        S_EST_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_SUM: begin
          mean_r <= '0;
          var_r  <= '0;
        end
        S_SUM_LOAD: begin
          out_res.kind     <= KIND_SUMMARY;
          out_res.idx      <= n_est;
          out_res.entropy  <= '0;
          out_res.mean     <= mean_r;
          out_res.variance <= var_r;
          out_res.last     <= 1'b1;
          out_valid        <= 1'b1;
        end
        S_SUM_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
